// ----- hdl/msf_pkg.sv -----
// shared types and constants for the multiset subset search block
package msf_pkg;

  // field widths of one input item and one result item
  localparam int OP_W    = 3;
  localparam int IDX_W   = 8;
  localparam int LET_W   = 5;
  localparam int CNT_W   = 4;
  localparam int KIND_W  = 6;
  localparam int ENT_W   = 9;
  localparam int OFF_W   = 9;
  localparam int CODE_W  = 15;
  localparam int CFG_W   = 64;
  localparam int CFG_A_W = 2;

  // packed stream widths, padded to whole bytes
  localparam int IN_TDATA_W  = 32;
  localparam int OUT_TDATA_W = 24;

  // opcodes
  localparam logic [OP_W-1:0] OP_WRITE  = 3'd0;
  localparam logic [OP_W-1:0] OP_SWAP   = 3'd1;
  localparam logic [OP_W-1:0] OP_BAG    = 3'd2;
  localparam logic [OP_W-1:0] OP_SEARCH = 3'd3;
  localparam logic [OP_W-1:0] OP_READ   = 3'd4;

  // configuration register indexes
  localparam logic [CFG_A_W-1:0] CFG_MAX_LO  = 2'd0;
  localparam logic [CFG_A_W-1:0] CFG_MAX_HI  = 2'd1;
  localparam logic [CFG_A_W-1:0] CFG_KINDS   = 2'd2;
  localparam logic [CFG_A_W-1:0] CFG_ENTRIES = 2'd3;

  // configuration reset values
  localparam logic [KIND_W-1:0] KINDS_RST   = 6'd27;
  localparam logic [ENT_W-1:0]  ENTRIES_RST = 9'd256;
  localparam logic [ENT_W-1:0]  SCAN_CAP    = 9'd256;

  // sequencer states
  typedef enum logic [3:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_OFFS,
    ST_RMW_RD,
    ST_RMW_WR,
    ST_BAG,
    ST_SW_A,
    ST_SW_B,
    ST_SW_WA,
    ST_SW_WB,
    ST_SCAN,
    ST_RD,
    ST_EMIT,
    ST_MISS
  } state_t;

endpackage

// ----- hdl/msf_entry_mem.sv -----
// entry store: one write port and one registered read port
module msf_entry_mem #(
  parameter int DEPTH = 256,
  parameter int WIDTH = 128,
  parameter int AW    = 8
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- hdl/msf_field_unit.sv -----
// shared field unit: thermometer masks for deposit and run count for decode
module msf_field_unit #(
  parameter int BITS = 128
) (
  input  logic [BITS-1:0]          map,
  input  logic [msf_pkg::OFF_W-1:0] off,
  input  logic [msf_pkg::CNT_W-1:0] mx,
  input  logic [msf_pkg::CNT_W-1:0] cnt,
  output logic [msf_pkg::CNT_W-1:0] run,
  output logic [BITS-1:0]          set_mask,
  output logic [BITS-1:0]          field_mask
);

  logic [msf_pkg::CNT_W-1:0]  csat;
  logic [msf_pkg::CODE_W-1:0] set_code;
  logic [msf_pkg::CODE_W-1:0] fld_code;
  logic [BITS-1:0]            shr;
  logic [msf_pkg::CODE_W:0]   win;

  // saturate the count and build both codes
  always_comb begin
    csat     = (cnt > mx) ? mx : cnt;
    set_code = msf_pkg::CODE_W'((16'd1 << csat) - 16'd1);
    fld_code = msf_pkg::CODE_W'((16'd1 << mx) - 16'd1);
  end

  // place codes at the field offset; bits past the map drop off
  assign set_mask   = BITS'(set_code) << off;
  assign field_mask = BITS'(fld_code) << off;

  // pull the field down and count the run of ones from its start
  always_comb begin
    shr = map >> off;
    win = {1'b0, shr[msf_pkg::CODE_W-1:0] & fld_code};
    run = msf_pkg::CNT_W'(msf_pkg::CODE_W);
    for (int i = msf_pkg::CODE_W; i >= 0; i--) begin
      if (!win[i]) begin
        run = msf_pkg::CNT_W'(i);
      end
    end
  end

endmodule

// ----- hdl/multiset_subset_first_match.sv -----
// top level: multiset table with a first-subset search, under one sequencer
//
//  channel  dir  handshake              payload
//  in_      in   in_tvalid/in_tready    tuser opcode; tdata index, other, letter, count
//  out_     out  out_tvalid/out_tready  tuser found; tdata index, letter, count; tlast
//  cfg_     in   cfg_we                 cfg_addr register index, cfg_wdata value
//
// write entry and load bag walk the letters below the target first; swap reads both, then
// writes both (one memory port each way); search reads one entry per cycle up to scan length;
// then one result per letter kind (or one not-found), one per cycle while out_tready is high
// after reset a clearing pass writes zero to all MAX_ENTRIES entries, one per cycle;
// in_tready stays low during it
// the output register lets a new item in while the last result waits to be taken
module multiset_subset_first_match #(
  parameter int MAX_ENTRIES = 256,
  parameter int BITMAP_BITS = 128,
  parameter int MAX_LETTERS = 32
) (
  input  logic                                clk,
  input  logic                                rst_n,
  // input item stream
  input  logic                                in_tvalid,
  output logic                                in_tready,
  input  logic [msf_pkg::IN_TDATA_W-1:0]      in_tdata,  // entry_index, other_entry, letter, count
  input  logic [msf_pkg::OP_W-1:0]            in_tuser,  // opcode
  // result stream
  output logic                                out_tvalid,
  input  logic                                out_tready,
  output logic [msf_pkg::OUT_TDATA_W-1:0]     out_tdata, // match_index, out_letter, out_count
  output logic                                out_tuser, // found
  output logic                                out_tlast,
  // configuration writes
  input  logic                                cfg_we,
  input  logic [msf_pkg::CFG_A_W-1:0]         cfg_addr,
  input  logic [msf_pkg::CFG_W-1:0]           cfg_wdata
);

  localparam int AW = (MAX_ENTRIES > 1) ? $clog2(MAX_ENTRIES) : 1;

  // configuration registers
  logic [msf_pkg::CFG_W-1:0]  mc0_r, mc1_r;
  logic [msf_pkg::KIND_W-1:0] kinds_r;
  logic [msf_pkg::ENT_W-1:0]  entries_r;

  // sequencer state and item registers
  msf_pkg::state_t            state_r, state_nxt;
  logic [msf_pkg::OP_W-1:0]   op_r, op_nxt;
  logic [msf_pkg::IDX_W-1:0]  ei_r, ei_nxt;
  logic [msf_pkg::IDX_W-1:0]  oe_r, oe_nxt;
  logic [msf_pkg::LET_W-1:0]  letter_r, letter_nxt;
  logic [msf_pkg::CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [msf_pkg::LET_W-1:0]  l_r, l_nxt;
  logic [msf_pkg::OFF_W-1:0]  off_r, off_nxt;
  logic [msf_pkg::ENT_W-1:0]  scan_r, scan_nxt;
  logic [msf_pkg::IDX_W-1:0]  chk_idx_r, chk_idx_nxt;
  logic                       chk_vld_r, chk_vld_nxt;
  logic [msf_pkg::IDX_W-1:0]  res_idx_r, res_idx_nxt;
  logic [AW-1:0]              clr_r, clr_nxt;
  logic [BITMAP_BITS-1:0]     hold_r, hold_nxt;
  logic [BITMAP_BITS-1:0]     bag_r, bag_nxt;

  // output register
  logic                       out_vld_r, out_vld_nxt;
  logic                       out_found_r, out_found_nxt;
  logic [msf_pkg::IDX_W-1:0]  out_idx_r, out_idx_nxt;
  logic [msf_pkg::LET_W-1:0]  out_let_r, out_let_nxt;
  logic [msf_pkg::CNT_W-1:0]  out_cnt_r, out_cnt_nxt;
  logic                       out_last_r, out_last_nxt;

  // memory port signals
  logic                       mem_we, mem_re;
  logic [AW-1:0]              mem_waddr, mem_raddr;
  logic [BITMAP_BITS-1:0]     mem_wdata, mem_rdata;

  // field unit signals
  logic [msf_pkg::CNT_W-1:0]  fu_run;
  logic [BITMAP_BITS-1:0]     fu_set, fu_field;

  // input field view
  logic [msf_pkg::IDX_W-1:0]  in_ei, in_oe;
  logic [msf_pkg::LET_W-1:0]  in_letter;
  logic [msf_pkg::CNT_W-1:0]  in_cnt;

  // derived values
  logic [2*msf_pkg::CFG_W-1:0] mc_all;
  logic [msf_pkg::CNT_W-1:0]   mx;
  logic [msf_pkg::KIND_W-1:0]  kinds;
  logic [msf_pkg::ENT_W-1:0]   lim_cap, lim;
  logic                        in_ei_ok, in_oe_ok;
  logic                        fits, hit, out_load, emit_last;

  assign in_ei     = in_tdata[7:0];
  assign in_oe     = in_tdata[15:8];
  assign in_letter = in_tdata[20:16];
  assign in_cnt    = in_tdata[24:21];

  // per-letter maximum and active kind count
  assign mc_all = {mc1_r, mc0_r};
  assign mx     = mc_all[{l_r, 2'b00} +: msf_pkg::CNT_W];
  assign kinds  = (kinds_r > msf_pkg::KIND_W'(MAX_LETTERS)) ?
                  msf_pkg::KIND_W'(MAX_LETTERS) : kinds_r;

  // scan length: min of entries_in_use, table depth and 256
  assign lim_cap = (entries_r > msf_pkg::SCAN_CAP) ? msf_pkg::SCAN_CAP : entries_r;
  assign lim     = (13'(lim_cap) > 13'(MAX_ENTRIES)) ?
                   msf_pkg::ENT_W'(MAX_ENTRIES) : lim_cap;

  assign in_ei_ok = 13'(in_ei) < 13'(MAX_ENTRIES);
  assign in_oe_ok = 13'(in_oe) < 13'(MAX_ENTRIES);

  // subset test of the entry just read against the bag
  assign fits = ((mem_rdata & ~bag_r) == '0);
  assign hit  = chk_vld_r && fits;

  assign out_load  = !out_vld_r || out_tready;
  assign emit_last = (kinds == '0) ||
                     ({1'b0, l_r} + msf_pkg::KIND_W'(1) == kinds);

  msf_entry_mem #(
    .DEPTH (MAX_ENTRIES),
    .WIDTH (BITMAP_BITS),
    .AW    (AW)
  ) u_mem (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (mem_rdata)
  );

  msf_field_unit #(
    .BITS (BITMAP_BITS)
  ) u_field (
    .map        (mem_rdata),
    .off        (off_r),
    .mx         (mx),
    .cnt        (cnt_r),
    .run        (fu_run),
    .set_mask   (fu_set),
    .field_mask (fu_field)
  );

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mc0_r     <= '0;
      mc1_r     <= '0;
      kinds_r   <= msf_pkg::KINDS_RST;
      entries_r <= msf_pkg::ENTRIES_RST;
    end else if (cfg_we) begin
      unique case (cfg_addr)
        msf_pkg::CFG_MAX_LO:  mc0_r     <= cfg_wdata;
        msf_pkg::CFG_MAX_HI:  mc1_r     <= cfg_wdata;
        msf_pkg::CFG_KINDS:   kinds_r   <= cfg_wdata[msf_pkg::KIND_W-1:0];
        msf_pkg::CFG_ENTRIES: entries_r <= cfg_wdata[msf_pkg::ENT_W-1:0];
        default: ;
      endcase
    end
  end

  // state register and control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= msf_pkg::ST_CLEAR;
      clr_r     <= '0;
      chk_vld_r <= 1'b0;
      out_vld_r <= 1'b0;
      bag_r     <= '0;
    end else begin
      state_r   <= state_nxt;
      clr_r     <= clr_nxt;
      chk_vld_r <= chk_vld_nxt;
      out_vld_r <= out_vld_nxt;
      bag_r     <= bag_nxt;
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    op_r        <= op_nxt;
    ei_r        <= ei_nxt;
    oe_r        <= oe_nxt;
    letter_r    <= letter_nxt;
    cnt_r       <= cnt_nxt;
    l_r         <= l_nxt;
    off_r       <= off_nxt;
    scan_r      <= scan_nxt;
    chk_idx_r   <= chk_idx_nxt;
    res_idx_r   <= res_idx_nxt;
    hold_r      <= hold_nxt;
    out_found_r <= out_found_nxt;
    out_idx_r   <= out_idx_nxt;
    out_let_r   <= out_let_nxt;
    out_cnt_r   <= out_cnt_nxt;
    out_last_r  <= out_last_nxt;
  end

  // sequencer: next state, memory controls and register updates
  always_comb begin
    state_nxt     = state_r;
    op_nxt        = op_r;
    ei_nxt        = ei_r;
    oe_nxt        = oe_r;
    letter_nxt    = letter_r;
    cnt_nxt       = cnt_r;
    l_nxt         = l_r;
    off_nxt       = off_r;
    scan_nxt      = scan_r;
    chk_idx_nxt   = chk_idx_r;
    chk_vld_nxt   = chk_vld_r;
    res_idx_nxt   = res_idx_r;
    clr_nxt       = clr_r;
    hold_nxt      = hold_r;
    bag_nxt       = bag_r;
    out_vld_nxt   = out_vld_r && !out_tready;
    out_found_nxt = out_found_r;
    out_idx_nxt   = out_idx_r;
    out_let_nxt   = out_let_r;
    out_cnt_nxt   = out_cnt_r;
    out_last_nxt  = out_last_r;
    mem_we        = 1'b0;
    mem_waddr     = AW'(ei_r);
    mem_wdata     = mem_rdata;
    mem_re        = 1'b0;
    mem_raddr     = AW'(ei_r);

    unique case (state_r)
      // zero the whole store after reset
      msf_pkg::ST_CLEAR: begin
        mem_we    = 1'b1;
        mem_waddr = clr_r;
        mem_wdata = '0;
        clr_nxt   = clr_r + AW'(1);
        if (clr_r == AW'(MAX_ENTRIES - 1)) begin
          state_nxt = msf_pkg::ST_IDLE;
        end
      end

      // take an item and dispatch on its opcode
      msf_pkg::ST_IDLE: begin
        if (in_tvalid) begin
          op_nxt      = in_tuser;
          ei_nxt      = in_ei;
          oe_nxt      = in_oe;
          letter_nxt  = in_letter;
          cnt_nxt     = in_cnt;
          l_nxt       = '0;
          off_nxt     = '0;
          scan_nxt    = '0;
          chk_vld_nxt = 1'b0;
          res_idx_nxt = in_ei;
          case (in_tuser)
            msf_pkg::OP_WRITE: begin
              if ({1'b0, in_letter} < kinds && in_ei_ok) begin
                state_nxt = msf_pkg::ST_OFFS;
              end
            end
            msf_pkg::OP_BAG: begin
              if ({1'b0, in_letter} < kinds) begin
                state_nxt = msf_pkg::ST_OFFS;
              end
            end
            msf_pkg::OP_SWAP: begin
              if (in_ei_ok && in_oe_ok) begin
                state_nxt = msf_pkg::ST_SW_A;
              end
            end
            msf_pkg::OP_SEARCH: begin
              res_idx_nxt = '0;
              state_nxt   = (lim == '0) ? msf_pkg::ST_MISS : msf_pkg::ST_SCAN;
            end
            msf_pkg::OP_READ: begin
              state_nxt = in_ei_ok ? msf_pkg::ST_RD : msf_pkg::ST_MISS;
            end
            default: ;
          endcase
        end
      end

      // walk the letters below the target, summing field widths
      msf_pkg::ST_OFFS: begin
        if (l_r == letter_r) begin
          state_nxt = (op_r == msf_pkg::OP_WRITE) ? msf_pkg::ST_RMW_RD : msf_pkg::ST_BAG;
        end else begin
          off_nxt = off_r + msf_pkg::OFF_W'(mx);
          l_nxt   = l_r + msf_pkg::LET_W'(1);
        end
      end

      // entry write: read, then or the code in
      msf_pkg::ST_RMW_RD: begin
        mem_re    = 1'b1;
        state_nxt = msf_pkg::ST_RMW_WR;
      end
      msf_pkg::ST_RMW_WR: begin
        mem_we    = 1'b1;
        mem_wdata = mem_rdata | fu_set;
        state_nxt = msf_pkg::ST_IDLE;
      end

      // bag load replaces the whole field
      msf_pkg::ST_BAG: begin
        bag_nxt   = (bag_r & ~fu_field) | fu_set;
        state_nxt = msf_pkg::ST_IDLE;
      end

      // swap: read both, write both
      msf_pkg::ST_SW_A: begin
        mem_re    = 1'b1;
        state_nxt = msf_pkg::ST_SW_B;
      end
      msf_pkg::ST_SW_B: begin
        mem_re    = 1'b1;
        mem_raddr = AW'(oe_r);
        hold_nxt  = mem_rdata;
        state_nxt = msf_pkg::ST_SW_WA;
      end
      msf_pkg::ST_SW_WA: begin
        mem_we    = 1'b1;
        state_nxt = msf_pkg::ST_SW_WB;
      end
      msf_pkg::ST_SW_WB: begin
        mem_we    = 1'b1;
        mem_waddr = AW'(oe_r);
        mem_wdata = hold_r;
        state_nxt = msf_pkg::ST_IDLE;
      end

      // scan: issue one read per cycle, test the previous one
      msf_pkg::ST_SCAN: begin
        if (hit) begin
          res_idx_nxt = chk_idx_r;
          state_nxt   = msf_pkg::ST_EMIT;
        end else if (scan_r == lim) begin
          state_nxt = msf_pkg::ST_MISS;
        end else begin
          mem_re      = 1'b1;
          mem_raddr   = AW'(scan_r);
          chk_idx_nxt = msf_pkg::IDX_W'(scan_r);
          chk_vld_nxt = 1'b1;
          scan_nxt    = scan_r + msf_pkg::ENT_W'(1);
        end
      end

      // read entry
      msf_pkg::ST_RD: begin
        mem_re    = 1'b1;
        state_nxt = msf_pkg::ST_EMIT;
      end

      // one count result per letter kind
      msf_pkg::ST_EMIT: begin
        if (out_load) begin
          out_vld_nxt   = 1'b1;
          out_found_nxt = 1'b1;
          out_idx_nxt   = res_idx_r;
          out_let_nxt   = l_r;
          out_cnt_nxt   = (kinds == '0) ? '0 : fu_run;
          out_last_nxt  = emit_last;
          off_nxt       = off_r + msf_pkg::OFF_W'(mx);
          l_nxt         = l_r + msf_pkg::LET_W'(1);
          if (emit_last) begin
            state_nxt = msf_pkg::ST_IDLE;
          end
        end
      end

      // single not-found result
      msf_pkg::ST_MISS: begin
        if (out_load) begin
          out_vld_nxt   = 1'b1;
          out_found_nxt = 1'b0;
          out_idx_nxt   = res_idx_r;
          out_let_nxt   = '0;
          out_cnt_nxt   = '0;
          out_last_nxt  = 1'b1;
          state_nxt     = msf_pkg::ST_IDLE;
        end
      end

      default: state_nxt = msf_pkg::ST_IDLE;
    endcase
  end

  // ports
  assign in_tready  = (state_r == msf_pkg::ST_IDLE);
  assign out_tvalid = out_vld_r;
  assign out_tuser  = out_found_r;
  assign out_tlast  = out_last_r;
  assign out_tdata  = {7'd0, out_cnt_r, out_let_r, out_idx_r};

`ifndef ASSERT_OFF
  // a not-found result always ends its run
  a_miss_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_tvalid && !out_tuser) |-> out_tlast)
    else $error("not-found result without last");

  // a hit lies inside the scan range
  a_hit_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msf_pkg::ST_SCAN && hit) |-> ({1'b0, chk_idx_r} < lim))
    else $error("search hit beyond scan length");

  // a search goes straight to scanning or to the miss result
  a_search_start: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready && in_tuser == msf_pkg::OP_SEARCH) |=>
      (state_r == msf_pkg::ST_SCAN || state_r == msf_pkg::ST_MISS))
    else $error("search did not start");

  // no memory read or write while a result run is being emitted
  a_emit_nowrite: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == msf_pkg::ST_EMIT) |-> (!mem_we && !mem_re))
    else $error("memory touched during result run");
`endif

endmodule

// ----- dv/tb_top.sv -----
// self-checking testbench for the multiset subset search block
`timescale 1ns / 100ps

module tb_top;

  localparam int MAX_ENTRIES   = 256;
  localparam int BITMAP_BITS   = 128;
  localparam int MAX_LETTERS   = 32;
  localparam int SETTLE_CYCLES = 48;
  localparam int STALL_LIMIT   = 4000;
  localparam int REPORT_CAP    = 50;
  localparam int IN_PAD_W      = msf_pkg::IN_TDATA_W - 2 * msf_pkg::IDX_W
                                 - msf_pkg::LET_W - msf_pkg::CNT_W;

  // opcodes the block ignores
  localparam logic [msf_pkg::OP_W-1:0] OP_SPARE_FIRST = 3'd5;
  localparam logic [msf_pkg::OP_W-1:0] OP_SPARE_LAST  = 3'd7;

  // one count result as it leaves the block
  typedef struct packed {
    logic                      found;
    logic [msf_pkg::IDX_W-1:0] index;
    logic [msf_pkg::LET_W-1:0] letter;
    logic [msf_pkg::CNT_W-1:0] count;
    logic                      last;
  } count_result_t;

  logic                            clk;
  logic                            rst_n;
  logic                            in_tvalid;
  logic                            in_tready;
  logic [msf_pkg::IN_TDATA_W-1:0]  in_tdata;   // entry_index, other_entry, letter, count
  logic [msf_pkg::OP_W-1:0]        in_tuser;   // opcode
  logic                            out_tvalid;
  logic                            out_tready;
  logic [msf_pkg::OUT_TDATA_W-1:0] out_tdata;  // match_index, out_letter, out_count
  logic                            out_tuser;  // found
  logic                            out_tlast;
  logic                            cfg_we;
  logic [msf_pkg::CFG_A_W-1:0]     cfg_addr;
  logic [msf_pkg::CFG_W-1:0]       cfg_wdata;

  // no idling on either side while set
  logic calm;
  int   mismatch_count;
  int   quiet_cycles;

  // shadow copy of the table, the bag and the registers
  logic [BITMAP_BITS-1:0]     table_model [MAX_ENTRIES];
  logic [BITMAP_BITS-1:0]     bag_model;
  logic [msf_pkg::CFG_W-1:0]  max_lo_model;
  logic [msf_pkg::CFG_W-1:0]  max_hi_model;
  logic [msf_pkg::KIND_W-1:0] kinds_model;
  logic [msf_pkg::ENT_W-1:0]  scan_model;

  count_result_t expected_counts [$];

  multiset_subset_first_match dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast),
    .cfg_we     (cfg_we),
    .cfg_addr   (cfg_addr),
    .cfg_wdata  (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // letter kinds in use, capped at the table width
  function automatic int live_kinds();
    return (kinds_model > MAX_LETTERS) ? MAX_LETTERS : int'(kinds_model);
  endfunction

  function automatic int field_width(input int l);
    logic [msf_pkg::CFG_W-1:0] word;
    word = (l < 16) ? max_lo_model : max_hi_model;
    return int'(word[4 * (l % 16) +: 4]);
  endfunction

  function automatic int field_base(input int l);
    int s;
    s = 0;
    for (int i = 0; i < l; i++) s += field_width(i);
    return s;
  endfunction

  // run of set bits from the field start; bits past the bitmap read as zero
  function automatic int decode_count(input logic [BITMAP_BITS-1:0] map, input int l);
    int base;
    int width;
    int n;
    base  = field_base(l);
    width = field_width(l);
    n     = 0;
    while (n < width && base + n < BITMAP_BITS && map[base + n]) n++;
    return n;
  endfunction

  // one result per letter kind, or a single empty one when no kinds are in use
  function automatic void queue_entry_counts(input logic [BITMAP_BITS-1:0] map,
                                             input logic [msf_pkg::IDX_W-1:0] idx);
    count_result_t r;
    int k;
    k = live_kinds();
    r.found = 1'b1;
    r.index = idx;
    if (k == 0) begin
      r.letter = '0;
      r.count  = '0;
      r.last   = 1'b1;
      expected_counts.push_back(r);
    end else begin
      for (int l = 0; l < k; l++) begin
        r.letter = msf_pkg::LET_W'(l);
        r.count  = msf_pkg::CNT_W'(decode_count(map, l));
        r.last   = (l == k - 1);
        expected_counts.push_back(r);
      end
    end
  endfunction

  // update the shadow state for one accepted item and queue its results
  function automatic void apply_item(input logic [msf_pkg::OP_W-1:0] op,
                                     input logic [msf_pkg::IDX_W-1:0] ei,
                                     input logic [msf_pkg::IDX_W-1:0] oe,
                                     input logic [msf_pkg::LET_W-1:0] letter,
                                     input logic [msf_pkg::CNT_W-1:0] cnt);
    int base;
    int width;
    int fill;
    int scan;
    bit hit;
    logic [BITMAP_BITS-1:0] held;
    count_result_t miss;
    case (op)
      msf_pkg::OP_WRITE, msf_pkg::OP_BAG: begin
        if (int'(letter) < live_kinds()) begin
          base  = field_base(letter);
          width = field_width(letter);
          fill  = (int'(cnt) > width) ? width : int'(cnt);
          for (int i = 0; i < width; i++) begin
            if (base + i < BITMAP_BITS) begin
              if (op == msf_pkg::OP_WRITE) begin
                if (i < fill) table_model[ei][base + i] = 1'b1;
              end else begin
                bag_model[base + i] = (i < fill);
              end
            end
          end
        end
      end
      msf_pkg::OP_SWAP: begin
        held            = table_model[ei];
        table_model[ei] = table_model[oe];
        table_model[oe] = held;
      end
      msf_pkg::OP_SEARCH: begin
        scan = (scan_model > MAX_ENTRIES) ? MAX_ENTRIES : int'(scan_model);
        hit  = 1'b0;
        for (int i = 0; i < scan; i++) begin
          if (!hit && (table_model[i] & ~bag_model) == '0) begin
            hit = 1'b1;
            queue_entry_counts(table_model[i], msf_pkg::IDX_W'(i));
          end
        end
        if (!hit) begin
          miss      = '0;
          miss.last = 1'b1;
          expected_counts.push_back(miss);
        end
      end
      msf_pkg::OP_READ: queue_entry_counts(table_model[ei], ei);
      default: ;
    endcase
  endfunction

  task automatic report_mismatch(input string what);
    if (mismatch_count < REPORT_CAP) $display("%0t result error: %s", $time, what);
    mismatch_count++;
  endtask

  // send one item, with an occasional gap ahead of it; valid stays high on return
  task automatic send_item(input logic [msf_pkg::OP_W-1:0] op,
                           input logic [msf_pkg::IDX_W-1:0] ei,
                           input logic [msf_pkg::IDX_W-1:0] oe,
                           input logic [msf_pkg::LET_W-1:0] letter,
                           input logic [msf_pkg::CNT_W-1:0] cnt);
    int gap;
    gap = (!calm && $urandom_range(0, 99) < 7) ? $urandom_range(1, 3) : 0;
    if (gap > 0) begin
      in_tvalid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser  <= op;
    in_tdata  <= {{IN_PAD_W{1'b0}}, cnt, letter, oe, ei};
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    apply_item(op, ei, oe, letter, cnt);
  endtask

  // wait for every result, then let a write still in progress finish
  task automatic wait_idle();
    in_tvalid <= 1'b0;
    while (expected_counts.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [msf_pkg::CFG_A_W-1:0] addr,
                           input logic [msf_pkg::CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_addr  <= addr;
    cfg_wdata <= value;
    @(posedge clk);
  endtask

  task automatic configure(input logic [msf_pkg::CFG_W-1:0] max_lo,
                           input logic [msf_pkg::CFG_W-1:0] max_hi,
                           input logic [msf_pkg::KIND_W-1:0] kinds,
                           input logic [msf_pkg::ENT_W-1:0] scan);
    wait_idle();
    write_reg(msf_pkg::CFG_MAX_LO, max_lo);
    write_reg(msf_pkg::CFG_MAX_HI, max_hi);
    write_reg(msf_pkg::CFG_KINDS, msf_pkg::CFG_W'(kinds));
    write_reg(msf_pkg::CFG_ENTRIES, msf_pkg::CFG_W'(scan));
    cfg_we       <= 1'b0;
    max_lo_model = max_lo;
    max_hi_model = max_hi;
    kinds_model  = kinds;
    scan_model   = scan;
  endtask

  // sixteen maximum counts: random, all 15, small, or all zero
  function automatic logic [msf_pkg::CFG_W-1:0] random_max_word(input int mode);
    logic [msf_pkg::CFG_W-1:0] w;
    for (int k = 0; k < 16; k++) begin
      case (mode)
        0:       w[4 * k +: 4] = msf_pkg::CNT_W'($urandom_range(0, 15));
        1:       w[4 * k +: 4] = 4'hF;
        2:       w[4 * k +: 4] = msf_pkg::CNT_W'($urandom_range(0, 3));
        default: w[4 * k +: 4] = 4'h0;
      endcase
    end
    return w;
  endfunction

  // reset register values: every field is empty, so entry 0 always fits
  task automatic test_reset_defaults();
    send_item(msf_pkg::OP_READ, 8'd0, 8'd0, 5'd0, 4'd0);
    send_item(msf_pkg::OP_SEARCH, 8'd0, 8'd0, 5'd0, 4'd0);
  endtask

  // full fields, a field cut off by the bitmap end, swaps, hit and miss
  task automatic test_fields_and_swap();
    configure(64'hFFFF_FFFF_FFFF_FFFF, 64'h0123_4567_89AB_CDEF, 6'd32, 9'd3);
    send_item(msf_pkg::OP_WRITE, 8'd0, 8'd0, 5'd0, 4'd15);
    send_item(msf_pkg::OP_WRITE, 8'd0, 8'd0, 5'd8, 4'd15);
    send_item(msf_pkg::OP_WRITE, 8'd1, 8'd0, 5'd1, 4'd3);
    send_item(msf_pkg::OP_WRITE, 8'd2, 8'd0, 5'd2, 4'd5);
    send_item(msf_pkg::OP_WRITE, 8'd255, 8'd0, 5'd31, 4'd15);
    send_item(msf_pkg::OP_READ, 8'd0, 8'd0, 5'd0, 4'd0);
    send_item(msf_pkg::OP_SWAP, 8'd0, 8'd255, 5'd0, 4'd0);
    send_item(msf_pkg::OP_READ, 8'd255, 8'd0, 5'd0, 4'd0);
    send_item(msf_pkg::OP_READ, 8'd0, 8'd0, 5'd0, 4'd0);
    send_item(msf_pkg::OP_WRITE, 8'd0, 8'd0, 5'd3, 4'd1);
    // every scanned entry is non-empty and the bag is empty
    send_item(msf_pkg::OP_SEARCH, 8'd0, 8'd0, 5'd0, 4'd0);
    send_item(msf_pkg::OP_BAG, 8'd0, 8'd0, 5'd1, 4'd15);
    send_item(msf_pkg::OP_SEARCH, 8'd0, 8'd0, 5'd0, 4'd0);
    // a smaller bag count replaces the field, so entry 1 no longer fits
    send_item(msf_pkg::OP_BAG, 8'd0, 8'd0, 5'd1, 4'd2);
    send_item(msf_pkg::OP_SEARCH, 8'd0, 8'd0, 5'd0, 4'd0);
    for (int op = OP_SPARE_FIRST; op <= OP_SPARE_LAST; op++)
      send_item(msf_pkg::OP_W'(op), 8'hFF, 8'hFF, 5'h1F, 4'hF);
    send_item(msf_pkg::OP_SWAP, 8'd1, 8'd1, 5'd0, 4'd0);
  endtask

  // no letter kinds, zero scan length, too many kinds, saturated counts
  task automatic test_register_corners();
    configure(64'hFFFF_FFFF_FFFF_FFFF, 64'hFFFF_FFFF_FFFF_FFFF, 6'd0, 9'd0);
    send_item(msf_pkg::OP_READ, 8'd7, 8'd0, 5'd0, 4'd0);
    send_item(msf_pkg::OP_SEARCH, 8'd0, 8'd0, 5'd0, 4'd0);
    send_item(msf_pkg::OP_WRITE, 8'd7, 8'd0, 5'd0, 4'd4);
    configure(64'h1111_1111_1111_1111, 64'h2222_2222_2222_2222, 6'd63, 9'd511);
    send_item(msf_pkg::OP_WRITE, 8'd4, 8'd0, 5'd0, 4'd15);
    send_item(msf_pkg::OP_WRITE, 8'd4, 8'd0, 5'd31, 4'd2);
    send_item(msf_pkg::OP_READ, 8'd4, 8'd0, 5'd0, 4'd0);
    send_item(msf_pkg::OP_SEARCH, 8'd0, 8'd0, 5'd0, 4'd0);
  endtask

  // random mix, weighted toward entries inside the scan range and full bags
  task automatic test_random_traffic(input int n_items, input int lo_mode, input int hi_mode,
                                     input logic [msf_pkg::KIND_W-1:0] kinds,
                                     input logic [msf_pkg::ENT_W-1:0] scan,
                                     input bit steady);
    int roll;
    int live;
    int hot_top;
    logic [msf_pkg::OP_W-1:0]  op;
    logic [msf_pkg::IDX_W-1:0] ei;
    logic [msf_pkg::IDX_W-1:0] oe;
    logic [msf_pkg::LET_W-1:0] letter;
    logic [msf_pkg::CNT_W-1:0] cnt;
    configure(random_max_word(lo_mode), random_max_word(hi_mode), kinds, scan);
    calm <= steady;
    live    = live_kinds();
    hot_top = (scan_model == 0) ? 3 : ((scan_model > 250) ? 255 : int'(scan_model) + 2);
    for (int n = 0; n < n_items; n++) begin
      roll = $urandom_range(0, 99);
      if (roll < 35)      op = msf_pkg::OP_WRITE;
      else if (roll < 60) op = msf_pkg::OP_BAG;
      else if (roll < 68) op = msf_pkg::OP_SWAP;
      else if (roll < 82) op = msf_pkg::OP_SEARCH;
      else if (roll < 95) op = msf_pkg::OP_READ;
      else                op = msf_pkg::OP_W'($urandom_range(OP_SPARE_FIRST, OP_SPARE_LAST));
      ei = msf_pkg::IDX_W'(($urandom_range(0, 9) < 8) ? $urandom_range(0, hot_top)
                                                       : $urandom_range(0, 255));
      oe = msf_pkg::IDX_W'(($urandom_range(0, 9) < 8) ? $urandom_range(0, hot_top)
                                                       : $urandom_range(0, 255));
      letter = msf_pkg::LET_W'((live > 0 && $urandom_range(0, 9) < 8) ?
                               $urandom_range(0, live - 1) : $urandom_range(0, 31));
      cnt = msf_pkg::CNT_W'((op == msf_pkg::OP_BAG && $urandom_range(0, 9) < 6) ?
                            15 : $urandom_range(0, 15));
      send_item(op, ei, oe, letter, cnt);
    end
    calm <= 1'b0;
  endtask

  // result check, output stalls and the stall watchdog
  always @(posedge clk) begin : result_check
    count_result_t seen;
    count_result_t want;
    if (rst_n && out_tvalid && out_tready) begin
      seen.found  = out_tuser;
      seen.index  = out_tdata[msf_pkg::IDX_W-1:0];
      seen.letter = out_tdata[msf_pkg::IDX_W +: msf_pkg::LET_W];
      seen.count  = out_tdata[msf_pkg::IDX_W + msf_pkg::LET_W +: msf_pkg::CNT_W];
      seen.last   = out_tlast;
      if (expected_counts.size() == 0) begin
        report_mismatch($sformatf("unexpected item found=%0d index=%0d letter=%0d count=%0d",
                                  seen.found, seen.index, seen.letter, seen.count));
      end else begin
        want = expected_counts.pop_front();
        if (seen.found !== want.found || seen.index !== want.index ||
            seen.letter !== want.letter || seen.count !== want.count ||
            seen.last !== want.last)
          report_mismatch($sformatf(
            "got f=%0d i=%0d l=%0d c=%0d t=%0d, want f=%0d i=%0d l=%0d c=%0d t=%0d",
            seen.found, seen.index, seen.letter, seen.count, seen.last,
            want.found, want.index, want.letter, want.count, want.last));
      end
    end
    out_tready <= calm || ($urandom_range(0, 99) >= 7);
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready) || cfg_we)
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("multiset_subset_first_match: mismatch");
      $finish;
    end
  end

  initial begin
    in_tvalid      <= 1'b0;
    in_tdata       <= '0;
    in_tuser       <= '0;
    out_tready     <= 1'b0;
    cfg_we         <= 1'b0;
    cfg_addr       <= '0;
    cfg_wdata      <= '0;
    calm           <= 1'b0;
    rst_n          <= 1'b0;
    mismatch_count = 0;
    quiet_cycles   = 0;
    max_lo_model   = '0;
    max_hi_model   = '0;
    kinds_model    = msf_pkg::KINDS_RST;
    scan_model     = msf_pkg::ENTRIES_RST;
    bag_model      = '0;
    for (int i = 0; i < MAX_ENTRIES; i++) table_model[i] = '0;
    repeat (3) @(posedge clk);
    rst_n <= 1'b1;

    test_reset_defaults();
    test_fields_and_swap();
    test_register_corners();
    test_random_traffic(120, 2, 2, 6'd32, 9'd8, 1'b0);
    test_random_traffic(120, 0, 2, msf_pkg::KIND_W'($urandom_range(1, 32)),
                        msf_pkg::ENT_W'($urandom_range(1, 16)), 1'b1);
    test_random_traffic(120, 1, 1, 6'd32, 9'd256, 1'b0);
    test_random_traffic(120, 2, 3, msf_pkg::KIND_W'($urandom_range(0, 63)),
                        msf_pkg::ENT_W'($urandom_range(0, 511)), 1'b0);

    wait_idle();
    if (mismatch_count == 0 && expected_counts.size() == 0)
      $display("multiset_subset_first_match: match");
    else
      $display("multiset_subset_first_match: mismatch");
    $finish;
  end

endmodule
